// ===== rtl/core/tdp_pkg.sv =====
// Shared widths, constants and divider interface types for the prime test block.
package tdp_pkg;

	localparam int VALUE_BITS = 32;
	localparam int MAG_BITS   = VALUE_BITS - 1;
	localparam int CNT_BITS   = $clog2(MAG_BITS + 1);

	typedef logic [MAG_BITS-1:0] mag_t;
	typedef logic [CNT_BITS-1:0] cnt_t;

	localparam mag_t SMALLEST_PRIME = MAG_BITS'(2);
	localparam mag_t FIRST_DIVISOR  = MAG_BITS'(3);
	localparam mag_t DIVISOR_STEP   = MAG_BITS'(2);

	typedef struct packed {
		logic start;
		mag_t dividend;
		mag_t divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		mag_t quotient;
		mag_t remainder;
	} div_rsp_t;

endpackage

// ===== rtl/core/tdp_divider.sv =====
// Restoring divider that produces one quotient bit per cycle.
module tdp_divider
	import tdp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic             busy_q;
	logic             done_q;
	cnt_t             cnt_q;
	mag_t             quo_q;
	mag_t             rem_q;
	mag_t             div_q;
	logic [MAG_BITS:0] shifted;
	logic [MAG_BITS:0] diff;
	logic             fits;

	assign shifted = {rem_q, quo_q[MAG_BITS-1]};
	assign diff    = shifted - {1'b0, div_q};
	assign fits    = (shifted >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_BITS'(MAG_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - cnt_t'(1);
			if (cnt_q == cnt_t'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[MAG_BITS-2:0], fits};
			rem_q <= fits ? diff[MAG_BITS-1:0] : shifted[MAG_BITS-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

// ===== rtl/core/trial_division_prime_test.sv =====
// Negative, even and below-two values skip trial division and go straight to ST_DONE;
// otherwise one division is run per odd trial divisor from 3 up to the integer square root,
// on the shared one-bit-per-cycle divider (up to about 23170 divisors).
// Throughput: one item at a time; a new item is taken once the sequencer is idle.
// Reset: asynchronous, active low; clears the sequencer and the output valid.
module trial_division_prime_test
	import tdp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  is_prime
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t   state_q;
	mag_t     n_q;
	mag_t     d_q;
	logic     res_q;
	logic     out_valid_q;
	logic     is_prime_q;
	div_req_t div_req;
	div_rsp_t div_rsp;
	logic     accept;
	mag_t     mag;
	logic     trivial;
	logic     trivial_res;
	logic     found_root;
	logic     found_factor;
	logic     out_free;
	mag_t     next_d;

	tdp_divider u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign mag       = value[MAG_BITS-1:0];
	assign out_free  = !out_valid_q || !out_stall;
	assign next_d    = d_q + DIVISOR_STEP;

	always_comb begin
		trivial     = 1'b1;
		trivial_res = 1'b0;
		priority if (value[VALUE_BITS-1]) begin
			trivial_res = 1'b0;
		end else if (mag < SMALLEST_PRIME) begin
			trivial_res = 1'b0;
		end else if (mag == SMALLEST_PRIME) begin
			trivial_res = 1'b1;
		end else if (!mag[0]) begin
			trivial_res = 1'b0;
		end else begin
			trivial = 1'b0;
		end
	end

	assign found_root   = (d_q > div_rsp.quotient);
	assign found_factor = (div_rsp.remainder == '0);

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = n_q;
		div_req.divisor  = next_d;
		if (state_q == ST_IDLE) begin
			div_req.start    = accept && !trivial;
			div_req.dividend = mag;
			div_req.divisor  = FIRST_DIVISOR;
		end else if (state_q == ST_DIV) begin
			div_req.start = div_rsp.done && !found_root && !found_factor;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= trivial ? ST_DONE : ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_rsp.done && (found_root || found_factor)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					n_q   <= mag;
					d_q   <= FIRST_DIVISOR;
					res_q <= trivial_res;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					if (found_root) begin
						res_q <= 1'b1;
					end else if (found_factor) begin
						res_q <= 1'b0;
					end else begin
						d_q <= next_d;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					is_prime_q <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign is_prime  = is_prime_q;

	a_done_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV))
		else $error("divider finished outside trial division");

	a_odd_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (d_q[0] && (d_q >= FIRST_DIVISOR)))
		else $error("trial divisor is not odd or below three");

	a_odd_candidate: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (n_q[0] && (n_q >= FIRST_DIVISOR)))
		else $error("trial division started on an even or small value");

	a_no_output_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && out_stall) |=> (state_q == ST_DONE))
		else $error("result left the sequencer while output was blocked");

endmodule
